/* hw/rtl/ref_name_validator_unit_assert.svh */
// ----------------------------------------------------------------------------
// ref name validator assertion macros
// concurrent property checks, removed when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef REF_NAME_VALIDATOR_UNIT_ASSERT_SVH
`define REF_NAME_VALIDATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// property checked on every rising clock edge, ignored while reset is high
`define RNV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define RNV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RNV_ASSERT(label, clk, rst, prop, msg)
`define RNV_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* hw/rtl/rnv_pkg.sv */
// ----------------------------------------------------------------------------
// rnv_pkg
// shared types, character constants and lookup functions for the validator
// ----------------------------------------------------------------------------
package rnv_pkg;

   localparam int unsigned CharWidth    = 8;
   localparam int unsigned LenWidth     = 16;
   localparam int unsigned CountWidth   = LenWidth + 1;
   localparam int unsigned PrefixLen    = 5;
   localparam int unsigned PrefixIdxW   = 3;
   localparam int unsigned RspDataWidth = 8;

   localparam logic [LenWidth-1:0]  DefaultMaxLen = 16'd1024;
   localparam logic [CharWidth-1:0] CtrlLimit     = 8'h20;

   localparam logic [CharWidth-1:0] ChDot       = 8'h2E;
   localparam logic [CharWidth-1:0] ChSlash     = 8'h2F;
   localparam logic [CharWidth-1:0] ChBackslash = 8'h5C;
   localparam logic [CharWidth-1:0] ChTilde     = 8'h7E;
   localparam logic [CharWidth-1:0] ChCaret     = 8'h5E;
   localparam logic [CharWidth-1:0] ChColon     = 8'h3A;
   localparam logic [CharWidth-1:0] ChQuestion  = 8'h3F;
   localparam logic [CharWidth-1:0] ChStar      = 8'h2A;
   localparam logic [CharWidth-1:0] ChBracket   = 8'h5B;
   localparam logic [CharWidth-1:0] ChSpace     = 8'h20;
   localparam logic [CharWidth-1:0] ChR         = 8'h72;
   localparam logic [CharWidth-1:0] ChE         = 8'h65;
   localparam logic [CharWidth-1:0] ChF         = 8'h66;
   localparam logic [CharWidth-1:0] ChS         = 8'h73;

   typedef struct packed {
      logic [CharWidth-1:0] char_code;
      logic                 is_last;
      logic                 is_empty;
   } item_type;

   typedef struct packed {
      logic valid;
      logic safe;
   } verdict_type;

   // expected character of "refs/" at a given position
   function automatic logic [CharWidth-1:0] prefix_char(input logic [PrefixIdxW-1:0] idx);
      logic [CharWidth-1:0] ch;
      case (idx)
         3'd0:    ch = ChR;
         3'd1:    ch = ChE;
         3'd2:    ch = ChF;
         3'd3:    ch = ChS;
         3'd4:    ch = ChSlash;
         default: ch = '0;
      endcase
      return ch;
   endfunction

   function automatic logic forbidden_char(input logic [CharWidth-1:0] ch);
      return (ch < CtrlLimit) || (ch == ChBackslash) || (ch == ChTilde) ||
             (ch == ChCaret) || (ch == ChColon) || (ch == ChQuestion) ||
             (ch == ChStar) || (ch == ChBracket) || (ch == ChSpace);
   endfunction

endpackage

/* hw/rtl/rnv_in_stage.sv */
// ----------------------------------------------------------------------------
// rnv_in_stage
// input register holding one request until the checker takes it
// ----------------------------------------------------------------------------
module rnv_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rnv_pkg::item_type in_item,
   input  logic              take,
   output logic              stage_valid,
   output rnv_pkg::item_type stage_item
);

   logic              valid_ff;
   logic              valid_in;
   rnv_pkg::item_type item_ff;
   logic              accept;

   // free when empty or being drained this cycle
   assign in_ready = !valid_ff || take;
   assign accept   = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= in_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

/* hw/rtl/rnv_checker.sv */
// ----------------------------------------------------------------------------
// rnv_checker
// per-name state and rule checks, one character per step
// ----------------------------------------------------------------------------
module rnv_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  rnv_pkg::item_type              item,
   input  logic [rnv_pkg::LenWidth-1:0]   max_len,
   output rnv_pkg::verdict_type           verdict
);

   logic [rnv_pkg::CountWidth-1:0] count_ff;
   logic [rnv_pkg::CountWidth-1:0] count_in;
   logic [rnv_pkg::CharWidth-1:0]  prev_ff;
   logic [rnv_pkg::CharWidth-1:0]  prev_in;
   logic                           prefix_ff;
   logic                           prefix_in;
   logic                           bad_ff;
   logic                           bad_in;

   logic [rnv_pkg::CountWidth-1:0] max_ext;
   logic [rnv_pkg::CharWidth-1:0]  ch;
   logic                           in_prefix;
   logic                           pair_bad;
   logic [rnv_pkg::CountWidth-1:0] count_next;
   logic                           prefix_next;
   logic                           bad_next;
   logic                           safe;

   assign max_ext   = {1'b0, max_len};
   assign ch        = item.char_code;
   assign in_prefix = count_ff < rnv_pkg::CountWidth'(rnv_pkg::PrefixLen);

   // doubled dot or slash
   assign pair_bad = (count_ff != '0) && (prev_ff == ch) &&
                     ((ch == rnv_pkg::ChDot) || (ch == rnv_pkg::ChSlash));

   assign prefix_next = prefix_ff &&
      !(in_prefix && (ch != rnv_pkg::prefix_char(count_ff[rnv_pkg::PrefixIdxW-1:0])));
   assign bad_next    = bad_ff || rnv_pkg::forbidden_char(ch) || pair_bad;

   // saturates one above the maximum
   assign count_next = (count_ff <= max_ext) ? count_ff + 1'b1 : count_ff;

   assign safe = !bad_next && prefix_next &&
                 (count_next >= rnv_pkg::CountWidth'(rnv_pkg::PrefixLen)) &&
                 (count_next <= max_ext) && (ch != rnv_pkg::ChSlash);

   always_comb begin
      count_in  = count_ff;
      prev_in   = prev_ff;
      prefix_in = prefix_ff;
      bad_in    = bad_ff;
      if (step) begin
         if (item.is_empty || item.is_last) begin
            count_in  = '0;
            prev_in   = '0;
            prefix_in = 1'b1;
            bad_in    = 1'b0;
         end else begin
            count_in  = count_next;
            prev_in   = ch;
            prefix_in = prefix_next;
            bad_in    = bad_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         prev_ff   <= '0;
         prefix_ff <= 1'b1;
         bad_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         prev_ff   <= prev_in;
         prefix_ff <= prefix_in;
         bad_ff    <= bad_in;
      end
   end

   assign verdict.valid = step && (item.is_empty || item.is_last);
   assign verdict.safe  = !item.is_empty && safe;

endmodule

/* hw/rtl/rnv_out_stage.sv */
// ----------------------------------------------------------------------------
// rnv_out_stage
// result register, holds a verdict until the downstream side takes it
// ----------------------------------------------------------------------------
module rnv_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  rnv_pkg::verdict_type verdict,
   output logic                 free,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 out_safe
);

   logic valid_ff;
   logic valid_in;
   logic safe_ff;

   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (verdict.valid) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (verdict.valid) begin
         safe_ff <= verdict.safe;
      end
   end

   assign out_valid = valid_ff;
   assign out_safe  = safe_ff;

endmodule

/* hw/rtl/ref_name_validator_unit.sv */
// ----------------------------------------------------------------------------
// ref_name_validator_unit: reference name checker, one character per request
// path: the last request of a name is held in the input register, then its verdict in the result register
// throughput: one request per cycle while the result register is free; the checker stage is combinational
// reset: synchronous; state cleared, maximum length back to 1024
// ----------------------------------------------------------------------------
`include "ref_name_validator_unit_assert.svh"

module ref_name_validator_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rnv_pkg::CharWidth-1:0]       req_tdata,   // [7:0] char_code
   input  logic                                req_tlast,   // is_last
   input  logic                                req_tuser,   // is_empty
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rnv_pkg::RspDataWidth-1:0]    rsp_tdata,   // [0] safe, [7:1] zero
   // maximum length register
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rnv_pkg::LenWidth-1:0]        csr_data
);

   logic [rnv_pkg::LenWidth-1:0] max_len_ff;
   logic [rnv_pkg::LenWidth-1:0] max_len_in;

   rnv_pkg::item_type    req_item;
   rnv_pkg::item_type    s1_item;
   logic                 s1_valid;
   logic                 s1_take;
   logic                 out_free;
   rnv_pkg::verdict_type verdict;
   logic                 rsp_safe;

   assign csr_ready  = 1'b1;
   assign max_len_in = (csr_valid && csr_ready) ? csr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= rnv_pkg::DefaultMaxLen;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign req_item.char_code = req_tdata;
   assign req_item.is_last   = req_tlast;
   assign req_item.is_empty  = req_tuser;

   assign s1_take = s1_valid && out_free;

   rnv_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_item     (req_item),
      .take        (s1_take),
      .stage_valid (s1_valid),
      .stage_item  (s1_item)
   );

   rnv_checker u_checker (
      .clock   (clock),
      .reset   (reset),
      .step    (s1_take),
      .item    (s1_item),
      .max_len (max_len_ff),
      .verdict (verdict)
   );

   rnv_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .verdict   (verdict),
      .free      (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_safe  (rsp_safe)
   );

   assign rsp_tdata = {{(rnv_pkg::RspDataWidth-1){1'b0}}, rsp_safe};

   // a stalled request in the input register must not move
   `RNV_ASSERT(a_s1_hold, clock, reset, (s1_valid && !out_free) |=> (s1_valid && $stable(s1_item)), "input stage lost or changed a stalled request")

   // an empty name always gives an unsafe verdict next cycle
   `RNV_ASSERT(a_empty_unsafe, clock, reset, (s1_take && s1_item.is_empty) |=> (rsp_tvalid && !rsp_tdata[0]), "empty name not rejected")

   // a name ending in slash is never safe
   `RNV_ASSERT(a_slash_end, clock, reset, (s1_take && s1_item.is_last && (s1_item.char_code == rnv_pkg::ChSlash)) |=> (rsp_tvalid && !rsp_tdata[0]), "trailing slash accepted")

   // a verdict is only produced into a free result register
   `RNV_ASSERT(a_no_overwrite, clock, reset, (!verdict.valid || out_free), "verdict overwrote a pending result")

endmodule
